// File: hw/rtl/sbeu_pkg.sv
// Package for the sixteen-bit execute unit: command codes and width constants.
// Used by sixteen_bit_execute_unit_with_flags; sbeu_div does not import it.
package sbeu_pkg;

  localparam int unsigned CmdW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 5'd0,  CMD_OR   = 5'd1,  CMD_ADC  = 5'd2,  CMD_SBB  = 5'd3,
    CMD_AND  = 5'd4,  CMD_SUB  = 5'd5,  CMD_XOR  = 5'd6,  CMD_CMP  = 5'd7,
    CMD_ROL  = 5'd8,  CMD_ROR  = 5'd9,  CMD_SHL  = 5'd10, CMD_SHR  = 5'd11,
    CMD_SAR  = 5'd12, CMD_NOT  = 5'd13, CMD_NEG  = 5'd14, CMD_MUL  = 5'd15,
    CMD_IMUL = 5'd16, CMD_DIV  = 5'd17, CMD_IDIV = 5'd18, CMD_AAM  = 5'd19,
    CMD_AAD  = 5'd20, CMD_AAA  = 5'd21, CMD_AAS  = 5'd22
  } cmd_e;

  // Flag bundle carried between the sequencer and the datapath
  typedef struct packed {
    logic z;
    logic s;
    logic c;
  } flags_t;

endpackage

// File: hw/rtl/sbeu_div.sv
// Iterative restoring divider, one quotient bit per cycle, 32 / 16 unsigned.
// Does not import sbeu_pkg.
module sbeu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [4:0]  steps_i,   // number of quotient bits to develop
  input  logic [31:0] num_i,     // dividend, left aligned to steps_i bits
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [16:0] rem_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [17:0] trial;
  logic [16:0] shifted;

  // One shift-and-subtract step
  always_comb begin
    shifted = {rem_q[15:0], quo_q[31]};
    trial   = {1'b0, shifted} - {2'b00, den_i};
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      quo_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial[17]) begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[16:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q - 5'd1;
      // Last step: quotient and remainder are registered together with done_q
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// File: hw/rtl/sixteen_bit_execute_unit_with_flags.sv
// Sixteen-bit execute unit with persistent carry, zero and sign flags.
// ALU/not/neg/aad/aaa/aas, unused codes, zero-count shifts and zero divisors finish
// in the execute state; shifts and rotates take one step per count, multiplies go
// through one registered 16x16 product, and divide and aam take one restoring step
// per quotient bit plus a register for completion.
// One command at a time; in_ready_o is low until the result is transferred.
// rst_ni (async, active low) clears the flags and the sequencer.
module sixteen_bit_execute_unit_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  command_i,
  input  logic        wide_i,
  input  logic [31:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic [7:0]  shift_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_low_o,
  output logic [15:0] result_high_o,
  output logic        zero_out_o,
  output logic        sign_out_o,
  output logic        carry_out_o,
  output logic        fault_o
);
  import sbeu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SHIFT, ST_MUL, ST_DIV, ST_OUT
  } state_e;

  state_e      state_q;
  flags_t      flg_q;
  logic [4:0]  cmd_q;
  logic        wide_q;
  logic [31:0] opa_q;
  logic [15:0] opb_q;
  logic [7:0]  cnt_q;
  logic [15:0] v_q;
  logic        c_q;
  logic [31:0] prod_q;
  logic        neg_q, negr_q;
  logic [15:0] lo_q, hi_q;
  logic        flt_q;

  // Width helpers
  logic [15:0] m, sbit, a, b;
  assign m    = wide_q ? 16'hFFFF : 16'h00FF;
  assign sbit = wide_q ? 16'h8000 : 16'h0080;
  assign a    = opa_q[15:0] & m;
  assign b    = opb_q & m;

  // Two-operand ALU
  logic [16:0] alu_r;
  logic        alu_c;
  logic [15:0] alu_m;
  always_comb begin
    alu_r = '0;
    alu_c = 1'b0;
    unique case (cmd_q[2:0])
      3'd0: alu_r = {1'b0, a} + {1'b0, b};
      3'd1: alu_r = {1'b0, a | b};
      3'd2: alu_r = {1'b0, a} + {1'b0, b} + {16'd0, flg_q.c};
      3'd3: alu_r = {1'b0, a} - {1'b0, b} - {16'd0, flg_q.c};
      3'd4: alu_r = {1'b0, a & b};
      3'd6: alu_r = {1'b0, a ^ b};
      default: alu_r = {1'b0, a} - {1'b0, b};
    endcase
    alu_m = alu_r[15:0] & m;
    unique case (cmd_q[2:0])
      3'd0, 3'd2: alu_c = wide_q ? alu_r[16] : alu_r[8];
      3'd3, 3'd5, 3'd7: alu_c = alu_r[16];
      default: alu_c = 1'b0;
    endcase
  end

  // Single shift step
  logic [15:0] sh_v;
  logic        sh_c, msb;
  always_comb begin
    msb  = wide_q ? v_q[15] : v_q[7];
    sh_v = v_q;
    sh_c = c_q;
    unique case (cmd_q)
      CMD_ROL: begin sh_c = msb; sh_v = ({v_q[14:0], msb}) & m; end
      CMD_ROR: begin sh_c = v_q[0]; sh_v = (v_q >> 1) | (v_q[0] ? sbit : 16'd0); end
      CMD_SHL: begin sh_c = msb; sh_v = {v_q[14:0], 1'b0} & m; end
      CMD_SHR: begin sh_c = v_q[0]; sh_v = v_q >> 1; end
      default: begin sh_c = v_q[0]; sh_v = (v_q >> 1) | (v_q & sbit); end
    endcase
  end

  // Divider operands: magnitudes, aligned to the number of quotient bits
  logic        is_aam, div_start, div_done;
  logic [31:0] num_mag, div_num, div_quo;
  logic [15:0] den_mag, den_raw;
  logic [16:0] div_rem;
  logic [4:0]  div_steps;
  logic        nsg, dsg;
  always_comb begin
    is_aam  = (cmd_q == CMD_AAM);
    den_raw = is_aam ? {8'd0, opb_q[7:0]} : b;
    nsg = 1'b0;
    dsg = 1'b0;
    if (cmd_q == CMD_IDIV) begin
      nsg = wide_q ? opa_q[31] : opa_q[15];
      dsg = wide_q ? b[15] : b[7];
    end
    if (is_aam)      num_mag = {24'd0, opa_q[7:0]};
    else if (wide_q) num_mag = nsg ? (32'd0 - opa_q) : opa_q;
    else             num_mag = nsg ? {16'd0, 16'd0 - opa_q[15:0]} : {16'd0, opa_q[15:0]};
    den_mag   = dsg ? (16'd0 - den_raw) & m : den_raw;
    div_steps = is_aam ? 5'd8 : (wide_q ? 5'd0 : 5'd16); // 0 means 32 via wrap
    if (is_aam)      div_num = {opa_q[7:0], 24'd0};
    else if (wide_q) div_num = num_mag;
    else             div_num = {num_mag[15:0], 16'd0};
  end

  sbeu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .steps_i (div_steps),
    .num_i   (div_num),
    .den_i   (den_mag),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  logic div_zero;
  assign div_zero  = (den_raw == 16'd0);
  assign div_start = (state_q == ST_EXEC) &&
                     (cmd_q == CMD_DIV || cmd_q == CMD_IDIV || cmd_q == CMD_AAM) && !div_zero;

  // Multiplier operands
  logic [15:0] ma, mb;
  logic        msa, msb2;
  assign msa  = (cmd_q == CMD_IMUL) && (wide_q ? a[15] : a[7]);
  assign msb2 = (cmd_q == CMD_IMUL) && (wide_q ? b[15] : b[7]);
  assign ma   = msa ? (16'd0 - a) & m : a;
  assign mb   = msb2 ? (16'd0 - b) & m : b;

  logic [31:0] sp;
  logic [15:0] q16, r16;
  logic [7:0]  aad_l;
  logic [15:0] aad_p;
  logic [7:0]  al, ah;
  logic        adj;
  always_comb begin
    sp    = negr_q ? 32'd0 - prod_q : prod_q;
    q16   = neg_q  ? 16'd0 - div_quo[15:0] : div_quo[15:0];
    r16   = negr_q ? 16'd0 - div_rem[15:0] : div_rem[15:0];
    aad_p = {8'd0, opa_q[15:8]} * {8'd0, opb_q[7:0]};
    aad_l = aad_p[7:0] + opa_q[7:0];
    adj   = (opa_q[3:0] > 4'd9) || flg_q.c;
    al    = opa_q[7:0];
    ah    = opa_q[15:8];
    if (adj) begin
      if (cmd_q == CMD_AAA) begin al = al + 8'd6; ah = ah + 8'd1; end
      else                  begin al = al - 8'd6; ah = ah - 8'd1; end
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign result_low_o  = lo_q;
  assign result_high_o = hi_q;
  assign zero_out_o    = flg_q.z;
  assign sign_out_o    = flg_q.s;
  assign carry_out_o   = flg_q.c;
  assign fault_o       = flt_q;

  // Sequencer, flags and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      flg_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            wide_q  <= wide_i;
            opa_q   <= operand_a_i;
            opb_q   <= operand_b_i;
            cnt_q   <= shift_count_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          lo_q  <= '0;
          hi_q  <= '0;
          flt_q <= 1'b0;
          state_q <= ST_OUT;
          if (cmd_q <= CMD_CMP) begin
            lo_q  <= (cmd_q == CMD_CMP) ? a : alu_m;
            flg_q <= '{z: (alu_m == 16'd0), s: |(alu_m & sbit), c: alu_c};
          end else if (cmd_q <= CMD_SAR) begin
            v_q <= a;
            c_q <= flg_q.c;
            if (cnt_q == 8'd0) lo_q <= a;
            else state_q <= ST_SHIFT;
          end else if (cmd_q == CMD_NOT) begin
            lo_q <= ~a & m;
          end else if (cmd_q == CMD_NEG) begin
            lo_q  <= (16'd0 - a) & m;
            flg_q <= '{z: (a == 16'd0), s: |((16'd0 - a) & sbit), c: (a != 16'd0)};
          end else if (cmd_q == CMD_MUL || cmd_q == CMD_IMUL) begin
            prod_q  <= ma * mb;
            negr_q  <= msa ^ msb2;
            state_q <= ST_MUL;
          end else if (cmd_q == CMD_DIV || cmd_q == CMD_IDIV || cmd_q == CMD_AAM) begin
            if (div_zero) begin
              flt_q <= 1'b1;
              lo_q  <= opa_q[15:0];
              hi_q  <= (wide_q && !is_aam) ? opa_q[31:16] : 16'd0;
            end else begin
              neg_q   <= nsg ^ dsg;
              negr_q  <= nsg;
              state_q <= ST_DIV;
            end
          end else if (cmd_q == CMD_AAD) begin
            lo_q  <= {8'd0, aad_l};
            flg_q <= '{z: (aad_l == 8'd0), s: aad_l[7], c: flg_q.c};
          end else if (cmd_q == CMD_AAA || cmd_q == CMD_AAS) begin
            lo_q    <= {ah, 4'd0, al[3:0]};
            flg_q.c <= adj;
          end
        end
        ST_SHIFT: begin
          v_q   <= sh_v;
          c_q   <= sh_c;
          cnt_q <= cnt_q - 8'd1;
          if (cnt_q == 8'd1) begin
            lo_q    <= sh_v;
            flg_q.c <= sh_c;
            if (cmd_q >= CMD_SHL) begin
              flg_q.z <= (sh_v == 16'd0);
              flg_q.s <= |(sh_v & sbit);
            end
            state_q <= ST_OUT;
          end
        end
        ST_MUL: begin
          lo_q <= sp[15:0];
          hi_q <= wide_q ? sp[31:16] : 16'd0;
          if (cmd_q == CMD_MUL) flg_q.c <= wide_q ? (sp[31:16] != 16'd0) : (sp[15:8] != 8'd0);
          else flg_q.c <= wide_q ? (sp[31:16] != {16{sp[15]}}) : (sp[15:8] != {8{sp[7]}});
          state_q <= ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            if (is_aam) begin
              lo_q  <= {div_quo[7:0], div_rem[7:0]};
              flg_q <= '{z: (div_rem[7:0] == 8'd0), s: div_rem[7], c: flg_q.c};
            end else if (wide_q) begin
              lo_q <= q16;
              hi_q <= r16;
            end else begin
              lo_q <= {r16[7:0], q16[7:0]};
            end
            state_q <= ST_OUT;
          end
        end
        default: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
